>>> rtl/io_image_with_point_mirroring_core_defines.svh
// assertion macros for the io image core
`ifndef IO_IMAGE_WITH_POINT_MIRRORING_CORE_DEFINES_SVH
`define IO_IMAGE_WITH_POINT_MIRRORING_CORE_DEFINES_SVH
`ifndef SYNTH
`define IPM_ASSERT_IMP(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
    else $error("ipm assertion failed");
`define IPM_ASSERT_NXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
    else $error("ipm assertion failed");
`else
`define IPM_ASSERT_IMP(lbl, c, r, ante, cons)
`define IPM_ASSERT_NXT(lbl, c, r, ante, cons)
`endif
`endif

>>> rtl/ipm_pkg.sv
package ipm_pkg;

  localparam int BIT_AREA_DEPTH = 2048;
  localparam int WORD_AREA_DEPTH = 1024;
  localparam int RULE_SLOTS = 64;
  localparam int NUM_BIT_AREAS = 14;
  localparam int NUM_WORD_AREAS = 10;
  localparam int BIT_TOTAL = NUM_BIT_AREAS * BIT_AREA_DEPTH;
  localparam int WORD_TOTAL = NUM_WORD_AREAS * WORD_AREA_DEPTH;
  localparam int BA_W = $clog2(BIT_TOTAL);
  localparam int WA_W = $clog2(WORD_TOTAL);
  localparam int PA_W = (BA_W > WA_W) ? BA_W : WA_W;
  localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int CLR_LEN = (BIT_TOTAL > WORD_TOTAL) ? BIT_TOTAL : WORD_TOTAL;
  localparam int CLR_W = $clog2(CLR_LEN);
  localparam int QDEPTH = 2;
  localparam logic [6:0] SW_MAX = 7'd127;

  localparam logic [2:0] MODE_READ = 3'd0;
  localparam logic [2:0] MODE_WRITE = 3'd1;
  localparam logic [2:0] MODE_LOAD = 3'd2;
  localparam logic [2:0] MODE_DISABLE = 3'd3;
  localparam logic [2:0] MODE_SWEEP = 3'd4;

  localparam logic [1:0] REG_COIL_COUNT = 2'd0;
  localparam logic [1:0] REG_DI_COUNT = 2'd1;
  localparam logic [1:0] REG_IR_COUNT = 2'd2;
  localparam logic [1:0] REG_HR_COUNT = 2'd3;

  typedef enum logic [2:0] {
    OP_READ, OP_WRITE, OP_LOAD, OP_DISABLE, OP_SWEEP, OP_NOP
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_RD_WAIT, S_SW_SLOT, S_SW_RULE, S_SW_SRC,
    S_SW_DST, S_SW_CMP
  } back_state_t;

  typedef struct packed {
    logic [11:0] coil_count;
    logic [11:0] di_count;
    logic [10:0] ir_count;
    logic [10:0] hr_count;
  } cfg_t;

  typedef struct packed {
    logic            ok;
    logic            is_word;
    logic [PA_W-1:0] addr;
  } point_t;

  typedef struct packed {
    logic [4:0]  src_area;
    logic [15:0] src_index;
    logic [4:0]  dst_area;
    logic [15:0] dst_index;
  } rule_t;

  typedef struct packed {
    op_t               op;
    logic              ok;
    point_t            pt;
    logic [15:0]       value;
    logic [SLOT_W-1:0] slot;
    rule_t             rule;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  function automatic point_t point_decode(logic [4:0] area, logic [15:0] idx, cfg_t c);
    logic [31:0] sz;
    logic [31:0] flat;
    point_t      p;
    if (area == 5'd0) begin
      sz = (32'(c.coil_count) < 32'(BIT_AREA_DEPTH)) ? 32'(c.coil_count) : 32'(BIT_AREA_DEPTH);
    end else if (area == 5'd1) begin
      sz = (32'(c.di_count) < 32'(BIT_AREA_DEPTH)) ? 32'(c.di_count) : 32'(BIT_AREA_DEPTH);
    end else if (32'(area) < 32'(NUM_BIT_AREAS)) begin
      sz = 32'(BIT_AREA_DEPTH);
    end else if (area == 5'd14) begin
      sz = (32'(c.ir_count) < 32'(WORD_AREA_DEPTH)) ? 32'(c.ir_count) : 32'(WORD_AREA_DEPTH);
    end else if (area == 5'd15) begin
      sz = (32'(c.hr_count) < 32'(WORD_AREA_DEPTH)) ? 32'(c.hr_count) : 32'(WORD_AREA_DEPTH);
    end else if (32'(area) < 32'(NUM_BIT_AREAS + NUM_WORD_AREAS)) begin
      sz = 32'(WORD_AREA_DEPTH);
    end else begin
      sz = 32'd0;
    end
    if (32'(area) < 32'(NUM_BIT_AREAS)) begin
      flat = 32'(area) * 32'(BIT_AREA_DEPTH) + 32'(idx);
      p.is_word = 1'b0;
    end else begin
      flat = (32'(area) - 32'(NUM_BIT_AREAS)) * 32'(WORD_AREA_DEPTH) + 32'(idx);
      p.is_word = 1'b1;
    end
    p.ok = (32'(idx) < sz);
    p.addr = flat[PA_W-1:0];
    return p;
  endfunction

endpackage

>>> rtl/ipm_if.sv
interface ipm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [4:0]  area;
  logic [15:0] index;
  logic [15:0] value;
  logic [5:0]  rule_slot;
  logic [4:0]  dst_area;
  logic [15:0] dst_index;
  modport source (output valid, mode, area, index, value, rule_slot, dst_area, dst_index,
                  input ready);
  modport sink (input valid, mode, area, index, value, rule_slot, dst_area, dst_index,
                output ready);
endinterface

interface ipm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        status;
  logic [6:0]  sweep_writes;
  modport source (output valid, read_data, status, sweep_writes, input ready);
  modport sink (input valid, read_data, status, sweep_writes, output ready);
endinterface

>>> rtl/io_image_with_point_mirroring_core.sv
// channel   dir  handshake      payload
// in_ch     in   valid/ready    mode area index value rule_slot dst_area dst_index
// out_ch    out  valid/ready    read_data status sweep_writes
// cfg       in   cfg_we         cfg_index cfg_wdata
// read: pop, EXEC, RD_WAIT, result reg; write/load/disable/unused mode: pop, EXEC, result reg
// sweep: EXEC, then SW_SLOT per slot, plus SW_RULE, SW_SRC, SW_DST, SW_CMP per enabled slot
// the next pop waits until the result beat has left out_ch
// after reset a clearing pass over every bit address zeroes both stores; in_ch.ready stays low
// a two-entry queue takes items while a result waits on out_ch
module io_image_with_point_mirroring_core (
  input  logic        clk,
  input  logic        rst_n,
  ipm_in_if.sink      in_ch,
  ipm_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);
  ipm_pkg::cfg_t         cfg;
  ipm_pkg::back_status_t bstat;
  ipm_pkg::entry_t       push_data, pop_data;
  logic                  push, full, pop, q_valid;

  ipm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .bstat(bstat), .q_full(full), .q_push(push),
    .q_data(push_data), .cfg(cfg));

  ipm_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .valid(q_valid), .data(pop_data));

  ipm_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .q_valid(q_valid), .q_data(pop_data),
    .q_pop(pop), .bstat(bstat), .out_ch(out_ch));
endmodule

>>> rtl/ipm_ram.sv
module ipm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/ipm_queue.sv
module ipm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ipm_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output ipm_pkg::entry_t data
);
  localparam int PW = (ipm_pkg::QDEPTH > 1) ? $clog2(ipm_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(ipm_pkg::QDEPTH + 1);

  ipm_pkg::entry_t slots_r [ipm_pkg::QDEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full = (cnt_r == CW'(ipm_pkg::QDEPTH));
  assign valid = (cnt_r != '0);
  assign data = slots_r[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(ipm_pkg::QDEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(ipm_pkg::QDEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slots_r[wp_r] <= push_data;
    end
  end
endmodule

>>> rtl/ipm_front.sv
module ipm_front (
  input  logic                   clk,
  input  logic                   rst_n,
  ipm_in_if.sink                 in_ch,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [11:0]            cfg_wdata,
  input  ipm_pkg::back_status_t  bstat,
  input  logic                   q_full,
  output logic                   q_push,
  output ipm_pkg::entry_t        q_data,
  output ipm_pkg::cfg_t          cfg
);
  ipm_pkg::cfg_t cfg_r, cfg_nxt;
  ipm_pkg::entry_t e;
  logic slot_ok;

  assign cfg = cfg_r;
  assign in_ch.ready = !bstat.clearing && !q_full;
  assign q_push = in_ch.valid && in_ch.ready;
  assign q_data = e;
  assign slot_ok = (32'(in_ch.rule_slot) < 32'(ipm_pkg::RULE_SLOTS));

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ipm_pkg::REG_COIL_COUNT: cfg_nxt.coil_count = cfg_wdata;
        ipm_pkg::REG_DI_COUNT:   cfg_nxt.di_count = cfg_wdata;
        ipm_pkg::REG_IR_COUNT:   cfg_nxt.ir_count = cfg_wdata[10:0];
        ipm_pkg::REG_HR_COUNT:   cfg_nxt.hr_count = cfg_wdata[10:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    e.pt = ipm_pkg::point_decode(in_ch.area, in_ch.index, cfg_r);
    e.value = in_ch.value;
    e.slot = ipm_pkg::SLOT_W'(in_ch.rule_slot);
    e.rule = {in_ch.area, in_ch.index, in_ch.dst_area, in_ch.dst_index};
    case (in_ch.mode)
      ipm_pkg::MODE_READ: begin
        e.op = ipm_pkg::OP_READ;
        e.ok = e.pt.ok;
      end
      ipm_pkg::MODE_WRITE: begin
        e.op = ipm_pkg::OP_WRITE;
        e.ok = e.pt.ok;
      end
      ipm_pkg::MODE_LOAD: begin
        e.op = ipm_pkg::OP_LOAD;
        e.ok = slot_ok;
      end
      ipm_pkg::MODE_DISABLE: begin
        e.op = ipm_pkg::OP_DISABLE;
        e.ok = slot_ok;
      end
      ipm_pkg::MODE_SWEEP: begin
        e.op = ipm_pkg::OP_SWEEP;
        e.ok = 1'b1;
      end
      default: begin
        e.op = ipm_pkg::OP_NOP;
        e.ok = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coil_count <= 12'd2048;
      cfg_r.di_count <= 12'd2048;
      cfg_r.ir_count <= 11'd1024;
      cfg_r.hr_count <= 11'd1024;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
endmodule

>>> rtl/ipm_back.sv
`include "io_image_with_point_mirroring_core_defines.svh"
module ipm_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ipm_pkg::cfg_t         cfg,
  input  logic                  q_valid,
  input  ipm_pkg::entry_t       q_data,
  output logic                  q_pop,
  output ipm_pkg::back_status_t bstat,
  ipm_out_if.source             out_ch
);
  ipm_pkg::back_state_t state_r, state_nxt;
  logic [ipm_pkg::CLR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  ipm_pkg::entry_t            cur_r, cur_nxt;
  logic [ipm_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [6:0]                 cnt_r, cnt_nxt, cnt_inc;
  ipm_pkg::point_t            srcp_r, srcp_nxt, dstp_r, dstp_nxt;
  logic [15:0]                ls_r, ls_nxt, ld_r, ld_nxt, s_r, s_nxt;
  logic [ipm_pkg::RULE_SLOTS-1:0] en_r, en_nxt, vis_r, vis_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [15:0]                out_rd_r, out_rd_nxt;
  logic                       out_st_r, out_st_nxt;
  logic [6:0]                 out_sw_r, out_sw_nxt;
  logic                       last_slot;

  logic                       bit_we, bit_wdata, bit_rdata;
  logic [ipm_pkg::BA_W-1:0]   bit_waddr, bit_raddr;
  logic                       word_we;
  logic [15:0]                word_wdata, word_rdata;
  logic [ipm_pkg::WA_W-1:0]   word_waddr, word_raddr;
  logic                       rule_we;
  ipm_pkg::rule_t             rule_rdata;
  logic                       hist_we;
  logic [31:0]                hist_wdata, hist_rdata;
  logic [15:0]                d_val, new_ls, new_ld;

  function automatic logic [15:0] pdata(ipm_pkg::point_t p, logic [15:0] w, logic b);
    logic [15:0] r;
    if (!p.ok) begin
      r = 16'd0;
    end else if (p.is_word) begin
      r = w;
    end else begin
      r = {15'd0, b};
    end
    return r;
  endfunction

  ipm_ram #(.WIDTH(1), .DEPTH(ipm_pkg::BIT_TOTAL)) u_bit_ram (
    .clk(clk), .we(bit_we), .waddr(bit_waddr), .wdata(bit_wdata),
    .raddr(bit_raddr), .rdata(bit_rdata));
  ipm_ram #(.WIDTH(16), .DEPTH(ipm_pkg::WORD_TOTAL)) u_word_ram (
    .clk(clk), .we(word_we), .waddr(word_waddr), .wdata(word_wdata),
    .raddr(word_raddr), .rdata(word_rdata));
  ipm_ram #(.WIDTH($bits(ipm_pkg::rule_t)), .DEPTH(ipm_pkg::RULE_SLOTS)) u_rule_ram (
    .clk(clk), .we(rule_we), .waddr(cur_r.slot), .wdata(cur_r.rule),
    .raddr(slot_r), .rdata(rule_rdata));
  ipm_ram #(.WIDTH(32), .DEPTH(ipm_pkg::RULE_SLOTS)) u_hist_ram (
    .clk(clk), .we(hist_we), .waddr(slot_r), .wdata(hist_wdata),
    .raddr(slot_r), .rdata(hist_rdata));

  assign bstat.clearing = (state_r == ipm_pkg::S_CLEAR);
  assign q_pop = (state_r == ipm_pkg::S_IDLE) && q_valid && !out_valid_r;
  assign last_slot = (slot_r == ipm_pkg::SLOT_W'(ipm_pkg::RULE_SLOTS - 1));
  assign cnt_inc = (cnt_r == ipm_pkg::SW_MAX) ? cnt_r : cnt_r + 7'd1;
  assign d_val = pdata(dstp_r, word_rdata, bit_rdata);
  assign out_ch.valid = out_valid_r;
  assign out_ch.read_data = out_rd_r;
  assign out_ch.status = out_st_r;
  assign out_ch.sweep_writes = out_sw_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ipm_pkg::S_CLEAR:
        if (clr_cnt_r == ipm_pkg::CLR_W'(ipm_pkg::CLR_LEN - 1)) state_nxt = ipm_pkg::S_IDLE;
      ipm_pkg::S_IDLE:
        if (q_pop) state_nxt = ipm_pkg::S_EXEC;
      ipm_pkg::S_EXEC: begin
        case (cur_r.op)
          ipm_pkg::OP_READ:  state_nxt = ipm_pkg::S_RD_WAIT;
          ipm_pkg::OP_SWEEP: state_nxt = ipm_pkg::S_SW_SLOT;
          default:           state_nxt = ipm_pkg::S_IDLE;
        endcase
      end
      ipm_pkg::S_RD_WAIT: state_nxt = ipm_pkg::S_IDLE;
      ipm_pkg::S_SW_SLOT: begin
        if (en_r[slot_r]) state_nxt = ipm_pkg::S_SW_RULE;
        else if (last_slot) state_nxt = ipm_pkg::S_IDLE;
      end
      ipm_pkg::S_SW_RULE: state_nxt = ipm_pkg::S_SW_SRC;
      ipm_pkg::S_SW_SRC:  state_nxt = ipm_pkg::S_SW_DST;
      ipm_pkg::S_SW_DST:  state_nxt = ipm_pkg::S_SW_CMP;
      ipm_pkg::S_SW_CMP:  state_nxt = last_slot ? ipm_pkg::S_IDLE : ipm_pkg::S_SW_SLOT;
      default: state_nxt = ipm_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    cur_nxt = cur_r;
    slot_nxt = slot_r;
    cnt_nxt = cnt_r;
    srcp_nxt = srcp_r;
    dstp_nxt = dstp_r;
    ls_nxt = ls_r;
    ld_nxt = ld_r;
    s_nxt = s_r;
    en_nxt = en_r;
    vis_nxt = vis_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_rd_nxt = out_rd_r;
    out_st_nxt = out_st_r;
    out_sw_nxt = out_sw_r;
    bit_we = 1'b0;
    bit_waddr = cur_r.pt.addr[ipm_pkg::BA_W-1:0];
    bit_wdata = |cur_r.value;
    bit_raddr = cur_r.pt.addr[ipm_pkg::BA_W-1:0];
    word_we = 1'b0;
    word_waddr = cur_r.pt.addr[ipm_pkg::WA_W-1:0];
    word_wdata = cur_r.value;
    word_raddr = cur_r.pt.addr[ipm_pkg::WA_W-1:0];
    rule_we = 1'b0;
    hist_we = 1'b0;
    new_ls = ls_r;
    new_ld = ld_r;
    hist_wdata = {new_ls, new_ld};
    case (state_r)
      ipm_pkg::S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ipm_pkg::CLR_W'(1);
        bit_we = (32'(clr_cnt_r) < 32'(ipm_pkg::BIT_TOTAL));
        bit_waddr = clr_cnt_r[ipm_pkg::BA_W-1:0];
        bit_wdata = 1'b0;
        word_we = (32'(clr_cnt_r) < 32'(ipm_pkg::WORD_TOTAL));
        word_waddr = clr_cnt_r[ipm_pkg::WA_W-1:0];
        word_wdata = 16'd0;
      end
      ipm_pkg::S_IDLE: begin
        if (q_pop) cur_nxt = q_data;
      end
      ipm_pkg::S_EXEC: begin
        case (cur_r.op)
          ipm_pkg::OP_WRITE: begin
            bit_we = cur_r.pt.ok && !cur_r.pt.is_word;
            word_we = cur_r.pt.ok && cur_r.pt.is_word;
            out_valid_nxt = 1'b1;
            out_rd_nxt = 16'd0;
            out_st_nxt = !cur_r.ok;
            out_sw_nxt = 7'd0;
          end
          ipm_pkg::OP_LOAD: begin
            if (cur_r.ok) begin
              rule_we = 1'b1;
              en_nxt[cur_r.slot] = 1'b1;
              vis_nxt[cur_r.slot] = 1'b0;
            end
            out_valid_nxt = 1'b1;
            out_rd_nxt = 16'd0;
            out_st_nxt = !cur_r.ok;
            out_sw_nxt = 7'd0;
          end
          ipm_pkg::OP_DISABLE: begin
            if (cur_r.ok) en_nxt[cur_r.slot] = 1'b0;
            out_valid_nxt = 1'b1;
            out_rd_nxt = 16'd0;
            out_st_nxt = !cur_r.ok;
            out_sw_nxt = 7'd0;
          end
          ipm_pkg::OP_SWEEP: begin
            slot_nxt = '0;
            cnt_nxt = 7'd0;
          end
          ipm_pkg::OP_READ: begin
          end
          default: begin
            out_valid_nxt = 1'b1;
            out_rd_nxt = 16'd0;
            out_st_nxt = 1'b0;
            out_sw_nxt = 7'd0;
          end
        endcase
      end
      ipm_pkg::S_RD_WAIT: begin
        out_valid_nxt = 1'b1;
        out_rd_nxt = pdata(cur_r.pt, word_rdata, bit_rdata);
        out_st_nxt = !cur_r.ok;
        out_sw_nxt = 7'd0;
      end
      ipm_pkg::S_SW_SLOT: begin
        if (!en_r[slot_r]) begin
          if (last_slot) begin
            out_valid_nxt = 1'b1;
            out_rd_nxt = 16'd0;
            out_st_nxt = 1'b0;
            out_sw_nxt = cnt_r;
          end else begin
            slot_nxt = slot_r + ipm_pkg::SLOT_W'(1);
          end
        end
      end
      ipm_pkg::S_SW_RULE: begin
        srcp_nxt = ipm_pkg::point_decode(rule_rdata.src_area, rule_rdata.src_index, cfg);
        dstp_nxt = ipm_pkg::point_decode(rule_rdata.dst_area, rule_rdata.dst_index, cfg);
        ls_nxt = hist_rdata[31:16];
        ld_nxt = hist_rdata[15:0];
      end
      ipm_pkg::S_SW_SRC: begin
        bit_raddr = srcp_r.addr[ipm_pkg::BA_W-1:0];
        word_raddr = srcp_r.addr[ipm_pkg::WA_W-1:0];
      end
      ipm_pkg::S_SW_DST: begin
        s_nxt = pdata(srcp_r, word_rdata, bit_rdata);
        bit_raddr = dstp_r.addr[ipm_pkg::BA_W-1:0];
        word_raddr = dstp_r.addr[ipm_pkg::WA_W-1:0];
      end
      ipm_pkg::S_SW_CMP: begin
        bit_waddr = dstp_r.addr[ipm_pkg::BA_W-1:0];
        word_waddr = dstp_r.addr[ipm_pkg::WA_W-1:0];
        bit_wdata = |s_r;
        word_wdata = s_r;
        if (!vis_r[slot_r]) begin
          new_ls = s_r;
          new_ld = d_val;
          if (s_r != d_val) begin
            new_ld = s_r;
            bit_we = dstp_r.ok && !dstp_r.is_word;
            word_we = dstp_r.ok && dstp_r.is_word;
            cnt_nxt = cnt_inc;
          end
        end else if (s_r != ls_r || (d_val == ld_r && s_r != d_val)) begin
          new_ls = s_r;
          new_ld = s_r;
          bit_we = dstp_r.ok && !dstp_r.is_word;
          word_we = dstp_r.ok && dstp_r.is_word;
          cnt_nxt = cnt_inc;
        end else if (d_val != ld_r) begin
          new_ls = d_val;
          new_ld = d_val;
          bit_waddr = srcp_r.addr[ipm_pkg::BA_W-1:0];
          word_waddr = srcp_r.addr[ipm_pkg::WA_W-1:0];
          bit_wdata = |d_val;
          word_wdata = d_val;
          bit_we = srcp_r.ok && !srcp_r.is_word;
          word_we = srcp_r.ok && srcp_r.is_word;
          cnt_nxt = cnt_inc;
        end
        hist_we = 1'b1;
        hist_wdata = {new_ls, new_ld};
        vis_nxt[slot_r] = 1'b1;
        if (last_slot) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt = 16'd0;
          out_st_nxt = 1'b0;
          out_sw_nxt = cnt_nxt;
        end else begin
          slot_nxt = slot_r + ipm_pkg::SLOT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipm_pkg::S_CLEAR;
      clr_cnt_r <= '0;
      en_r <= '0;
      vis_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      en_r <= en_nxt;
      vis_r <= vis_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r <= cur_nxt;
    slot_r <= slot_nxt;
    cnt_r <= cnt_nxt;
    srcp_r <= srcp_nxt;
    dstp_r <= dstp_nxt;
    ls_r <= ls_nxt;
    ld_r <= ld_nxt;
    s_r <= s_nxt;
    out_rd_r <= out_rd_nxt;
    out_st_r <= out_st_nxt;
    out_sw_r <= out_sw_nxt;
  end

  `IPM_ASSERT_IMP(a_no_result_in_clear, clk, rst_n, state_r == ipm_pkg::S_CLEAR, !out_valid_r)
  `IPM_ASSERT_IMP(a_pop_needs_free_out, clk, rst_n, q_pop, !out_valid_r)
  `IPM_ASSERT_NXT(a_skip_disabled, clk, rst_n,
                  state_r == ipm_pkg::S_SW_SLOT && !en_r[slot_r], state_r != ipm_pkg::S_SW_RULE)
endmodule

>>> dv/io_image_with_point_mirroring_core_tb.sv
module io_image_with_point_mirroring_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] M_READ = ipm_pkg::MODE_READ;
  localparam logic [2:0] M_WRITE = ipm_pkg::MODE_WRITE;
  localparam logic [2:0] M_LOAD = ipm_pkg::MODE_LOAD;
  localparam logic [2:0] M_DIS = ipm_pkg::MODE_DISABLE;
  localparam logic [2:0] M_SWEEP = ipm_pkg::MODE_SWEEP;
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam int NBA = ipm_pkg::NUM_BIT_AREAS;
  localparam int NWA = ipm_pkg::NUM_WORD_AREAS;
  localparam int BAD = ipm_pkg::BIT_AREA_DEPTH;
  localparam int WAD = ipm_pkg::WORD_AREA_DEPTH;
  localparam int SLOTS = ipm_pkg::RULE_SLOTS;
  localparam int NUM_AREAS = NBA + NWA;
  localparam int STALL_LIMIT = 100000;
  localparam int RANDOM_ITEMS = 900;
  localparam int QUIET_TAIL = 100;

  typedef struct {
    logic [2:0]  mode;
    logic [4:0]  area;
    logic [15:0] index;
    logic [15:0] value;
    logic [5:0]  slot;
    logic [4:0]  dst_area;
    logic [15:0] dst_index;
  } access_t;

  typedef struct {
    logic [15:0] read_data;
    logic        status;
    logic [6:0]  sweep_writes;
  } reply_t;

  typedef struct {
    access_t acc;
    bit      typed;
    reply_t  rep;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = ipm_pkg::REG_COIL_COUNT;
  logic [11:0] cfg_wdata = '0;

  ipm_in_if in_ch ();
  ipm_out_if out_ch ();

  io_image_with_point_mirroring_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // mirror of the image
  logic            bit_img [NBA*BAD];
  logic [15:0]     word_img [NWA*WAD];
  ipm_pkg::rule_t  rule_pts [SLOTS];
  logic [15:0]     seen_src [SLOTS];
  logic [15:0]     seen_dst [SLOTS];
  bit              rule_on [SLOTS];
  bit              rule_seen [SLOTS];
  int unsigned coils = 2048, dis = 2048, irs = 1024, hrs = 1024;

  reply_t reply_q[$];
  int     fail_cnt = 0;
  bit     quiet = 1'b0;
  int     idle_cycles = 0;
  int     out_stall = 0;

  function automatic int unsigned area_len(logic [4:0] a);
    if (a == 5'd0) return (coils < BAD) ? coils : BAD;
    if (a == 5'd1) return (dis < BAD) ? dis : BAD;
    if (a < NBA) return BAD;
    if (a == 5'd14) return (irs < WAD) ? irs : WAD;
    if (a == 5'd15) return (hrs < WAD) ? hrs : WAD;
    if (a < NUM_AREAS) return WAD;
    return 0;
  endfunction

  function automatic logic [15:0] peek(logic [4:0] a, logic [15:0] i);
    if (i >= area_len(a)) return 16'd0;
    if (a < NBA) return {15'd0, bit_img[a*BAD + i]};
    return word_img[(a - NBA)*WAD + i];
  endfunction

  function automatic bit poke(logic [4:0] a, logic [15:0] i, logic [15:0] v);
    if (i >= area_len(a)) return 1'b0;
    if (a < NBA) bit_img[a*BAD + i] = (v != 16'd0);
    else word_img[(a - NBA)*WAD + i] = v;
    return 1'b1;
  endfunction

  function automatic logic [6:0] mirror_sweep();
    int n;
    logic [15:0] s, d;
    bit ok;
    n = 0;
    for (int k = 0; k < SLOTS; k++) begin
      if (!rule_on[k]) continue;
      s = peek(rule_pts[k].src_area, rule_pts[k].src_index);
      d = peek(rule_pts[k].dst_area, rule_pts[k].dst_index);
      if (!rule_seen[k]) begin
        seen_src[k] = s;
        seen_dst[k] = d;
        if (s != d) begin
          ok = poke(rule_pts[k].dst_area, rule_pts[k].dst_index, s);
          seen_dst[k] = s;
          n++;
        end
        rule_seen[k] = 1'b1;
      end else if (s != seen_src[k] || (d == seen_dst[k] && s != d)) begin
        ok = poke(rule_pts[k].dst_area, rule_pts[k].dst_index, s);
        seen_src[k] = s;
        seen_dst[k] = s;
        n++;
      end else if (d != seen_dst[k]) begin
        ok = poke(rule_pts[k].src_area, rule_pts[k].src_index, d);
        seen_src[k] = d;
        seen_dst[k] = d;
        n++;
      end
    end
    return (n > 127) ? ipm_pkg::SW_MAX : 7'(n);
  endfunction

  function automatic reply_t image_step(access_t a);
    reply_t r;
    r = '{16'd0, 1'b0, 7'd0};
    case (a.mode)
      M_READ: begin
        r.read_data = peek(a.area, a.index);
        r.status = (a.index >= area_len(a.area));
      end
      M_WRITE: r.status = !poke(a.area, a.index, a.value);
      M_LOAD: begin
        rule_pts[a.slot] = '{a.area, a.index, a.dst_area, a.dst_index};
        rule_on[a.slot] = 1'b1;
        rule_seen[a.slot] = 1'b0;
      end
      M_DIS: rule_on[a.slot] = 1'b0;
      M_SWEEP: r.sweep_writes = mirror_sweep();
      default: ;
    endcase
    return r;
  endfunction

  task automatic send(vector_t v);
    reply_t p;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_ch.mode = v.acc.mode;
    in_ch.area = v.acc.area;
    in_ch.index = v.acc.index;
    in_ch.value = v.acc.value;
    in_ch.rule_slot = v.acc.slot;
    in_ch.dst_area = v.acc.dst_area;
    in_ch.dst_index = v.acc.dst_index;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    p = image_step(v.acc);
    reply_q.insert(reply_q.size(), v.typed ? v.rep : p);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [11:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      ipm_pkg::REG_COIL_COUNT: coils = val;
      ipm_pkg::REG_DI_COUNT: dis = val;
      ipm_pkg::REG_IR_COUNT: irs = val[10:0];
      default: hrs = val[10:0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [4:0] pick_area();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) begin
      case (r % 8)
        0: return 5'd0;
        1: return 5'd1;
        2: return 5'd2;
        3: return 5'd13;
        4: return 5'd14;
        5: return 5'd15;
        6: return 5'd16;
        default: return 5'd23;
      endcase
    end
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [15:0] pick_index(logic [4:0] a);
    int r;
    int unsigned n;
    r = $urandom_range(0, 19);
    n = area_len(a);
    if (r < 15) return 16'($urandom_range(0, 7));
    if (r < 18 && n > 0) return 16'(n - 1 + $urandom_range(0, 1));
    return 16'($urandom);
  endfunction

  function automatic access_t pick_access();
    access_t a;
    int r;
    a.mode = M_READ;
    a.area = pick_area();
    a.index = pick_index(a.area);
    a.value = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1)) : 16'($urandom);
    a.slot = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
    a.dst_area = pick_area();
    a.dst_index = pick_index(a.dst_area);
    r = $urandom_range(0, 99);
    if (r < 30) a.mode = M_WRITE;
    else if (r < 55) a.mode = M_READ;
    else if (r < 68) a.mode = M_LOAD;
    else if (r < 73) a.mode = M_DIS;
    else if (r < 88) a.mode = M_SWEEP;
    else if (r < 95) begin
      a.mode = 3'($urandom);
      a.area = 5'($urandom);
      a.index = 16'($urandom);
      a.dst_area = 5'($urandom);
      a.dst_index = 16'($urandom);
    end else a.mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    return a;
  endfunction

  vector_t directed [] = '{
    '{'{M_READ, 5'd0, 16'd0, 16'd0, 6'd0, 5'd0, 16'd0}, 1, '{16'd0, 1'b0, 7'd0}},
    '{'{M_WRITE, 5'd0, 16'd0, 16'hFFFF, 6'd0, 5'd0, 16'd0}, 1, '{16'd0, 1'b0, 7'd0}},
    '{'{M_READ, 5'd0, 16'd0, 16'd0, 6'd0, 5'd0, 16'd0}, 1, '{16'd1, 1'b0, 7'd0}},
    '{'{M_READ, 5'd31, 16'd0, 16'd0, 6'd0, 5'd0, 16'd0}, 1, '{16'd0, 1'b1, 7'd0}},
    '{'{M_WRITE, 5'd24, 16'd0, 16'hFFFF, 6'd0, 5'd0, 16'd0}, 1, '{16'd0, 1'b1, 7'd0}},
    '{'{M_READ, 5'd0, 16'd2048, 16'd0, 6'd0, 5'd0, 16'd0}, 1, '{16'd0, 1'b1, 7'd0}},
    '{'{M_WRITE, 5'd13, 16'hFFFF, 16'd1, 6'd0, 5'd0, 16'd0}, 1, '{16'd0, 1'b1, 7'd0}},
    '{'{M_WRITE, 5'd23, 16'd1023, 16'hFFFF, 6'd0, 5'd0, 16'd0}, 1, '{16'd0, 1'b0, 7'd0}},
    '{'{M_READ, 5'd23, 16'd1023, 16'd0, 6'd0, 5'd0, 16'd0}, 1, '{16'hFFFF, 1'b0, 7'd0}},
    '{'{M_READ, 5'd14, 16'd1024, 16'd0, 6'd0, 5'd0, 16'd0}, 1, '{16'd0, 1'b1, 7'd0}},
    '{'{MODE_UNUSED_LO, 5'd31, 16'hFFFF, 16'hFFFF, 6'd63, 5'd31, 16'hFFFF}, 1,
      '{16'd0, 1'b0, 7'd0}},
    '{'{MODE_UNUSED_HI, 5'd0, 16'd0, 16'd0, 6'd0, 5'd0, 16'd0}, 1, '{16'd0, 1'b0, 7'd0}},
    '{'{M_SWEEP, 5'd0, 16'd0, 16'd0, 6'd0, 5'd0, 16'd0}, 1, '{16'd0, 1'b0, 7'd0}},
    '{'{M_LOAD, 5'd15, 16'd5, 16'd0, 6'd0, 5'd16, 16'd5}, 1, '{16'd0, 1'b0, 7'd0}},
    '{'{M_WRITE, 5'd15, 16'd5, 16'h1234, 6'd0, 5'd0, 16'd0}, 0, '{16'd0, 1'b0, 7'd0}},
    '{'{M_SWEEP, 5'd0, 16'd0, 16'd0, 6'd0, 5'd0, 16'd0}, 1, '{16'd0, 1'b0, 7'd1}},
    '{'{M_READ, 5'd16, 16'd5, 16'd0, 6'd0, 5'd0, 16'd0}, 1, '{16'h1234, 1'b0, 7'd0}},
    '{'{M_WRITE, 5'd16, 16'd5, 16'hABCD, 6'd0, 5'd0, 16'd0}, 0, '{16'd0, 1'b0, 7'd0}},
    '{'{M_SWEEP, 5'd0, 16'd0, 16'd0, 6'd0, 5'd0, 16'd0}, 0, '{16'd0, 1'b0, 7'd0}},
    '{'{M_READ, 5'd15, 16'd5, 16'd0, 6'd0, 5'd0, 16'd0}, 0, '{16'd0, 1'b0, 7'd0}},
    '{'{M_LOAD, 5'd30, 16'hFFFF, 16'd0, 6'd63, 5'd2, 16'd0}, 0, '{16'd0, 1'b0, 7'd0}},
    '{'{M_LOAD, 5'd3, 16'd7, 16'd0, 6'd1, 5'd17, 16'd7}, 0, '{16'd0, 1'b0, 7'd0}},
    '{'{M_WRITE, 5'd3, 16'd7, 16'd5, 6'd0, 5'd0, 16'd0}, 0, '{16'd0, 1'b0, 7'd0}},
    '{'{M_DIS, 5'd0, 16'd0, 16'd0, 6'd0, 5'd0, 16'd0}, 1, '{16'd0, 1'b0, 7'd0}},
    '{'{M_SWEEP, 5'd0, 16'd0, 16'd0, 6'd0, 5'd0, 16'd0}, 0, '{16'd0, 1'b0, 7'd0}}
  };

  // count settings per phase: coil, discrete input, input reg, holding reg
  logic [11:0] phase_cfg [4][4] = '{
    '{12'd2048, 12'd2048, 12'd1024, 12'd1024},
    '{12'd0, 12'd4095, 12'd0, 12'd2047},
    '{12'd5, 12'd3, 12'd4, 12'd6},
    '{12'd2047, 12'd1, 12'd1023, 12'd1}
  };

  always @(negedge clk) begin
    if (quiet || !rst_n) begin
      out_ch.ready = rst_n;
    end else if (out_stall > 0) begin
      out_ch.ready = 1'b0;
      out_stall--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ch.ready = 1'b0;
      out_stall = $urandom_range(0, 14);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    reply_t e;
    if (out_ch.valid && out_ch.ready) begin
      if (reply_q.size() == 0) begin
        $error("result beat with no expectation waiting");
        fail_cnt++;
      end else begin
        e = reply_q.pop_front();
        if (out_ch.read_data !== e.read_data) begin
          $error("read_data: expected %0h, got %0h", e.read_data, out_ch.read_data);
          fail_cnt++;
        end
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_ch.status);
          fail_cnt++;
        end
        if (out_ch.sweep_writes !== e.sweep_writes) begin
          $error("sweep_writes: expected %0d, got %0d", e.sweep_writes, out_ch.sweep_writes);
          fail_cnt++;
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("io_image_with_point_mirroring_core: mismatch");
      $finish;
    end
  end

  initial begin
    vector_t v;
    int sent;
    in_ch.valid = 1'b0;
    in_ch.mode = M_READ;
    in_ch.area = '0;
    in_ch.index = '0;
    in_ch.value = '0;
    in_ch.rule_slot = '0;
    in_ch.dst_area = '0;
    in_ch.dst_index = '0;
    out_ch.ready = 1'b0;
    foreach (bit_img[k]) bit_img[k] = 1'b0;
    foreach (word_img[k]) word_img[k] = 16'd0;
    foreach (rule_on[k]) begin
      rule_on[k] = 1'b0;
      rule_seen[k] = 1'b0;
      seen_src[k] = 16'd0;
      seen_dst[k] = 16'd0;
      rule_pts[k] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (directed[k]) send(directed[k]);
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      for (int r = 0; r < 4; r++) set_reg(2'(r), phase_cfg[ph][r]);
      for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
        quiet = (sent >= RANDOM_ITEMS - QUIET_TAIL);
        v.acc = pick_access();
        v.typed = 1'b0;
        v.rep = '{16'd0, 1'b0, 7'd0};
        send(v);
        sent++;
      end
    end
    drain();
    repeat (30) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("io_image_with_point_mirroring_core: match");
    end else begin
      $display("io_image_with_point_mirroring_core: mismatch");
    end
    $finish;
  end

endmodule
